### src/rfa_pkg.sv
// Package for the rational fraction ALU: operation codes and width constants.
// No dependencies.
`default_nettype none
package rfa_pkg;
  localparam int OperandWidthDefault = 16;
  localparam int InWidth = 16;
  localparam int NumWidth = 32;
  localparam int DenWidth = 31;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_MUL = 2'd1,
    KIND_EQ  = 2'd2,
    KIND_LT  = 2'd3
  } kind_t;
endpackage
`default_nettype wire

### src/rational_fraction_alu_core.sv
// Top level of the rational fraction ALU: normalize, combine, reduce.
// Depends on rfa_pkg and rfa_gcd.
`default_nettype none
// One beat per start; busy stays high until the result strobe. Add and multiply
// run the binary GCD steps and then the divide steps for both parts through
// rfa_gcd's single shift/subtract unit; a zero sum or product, the tests and a
// zero denominator finish without the GCD. The result is shown for one cycle
// with done high and cannot be held off.
module rational_fraction_alu_core import rfa_pkg::*; #(
  parameter int OPERAND_WIDTH = OperandWidthDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  kind,
  input  wire logic signed [InWidth-1:0]   a_num,
  input  wire logic signed [InWidth-1:0]   a_den,
  input  wire logic signed [InWidth-1:0]   b_num,
  input  wire logic signed [InWidth-1:0]   b_den,
  output logic                             done,
  output logic signed [NumWidth-1:0]       res_num,
  output logic [DenWidth-1:0]              res_den,
  output logic                             flag,
  output logic                             status
);
  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW + 1;
  localparam int GW = 64;

  typedef enum logic [2:0] {S_IDLE, S_MUL1, S_MUL2, S_COMB, S_GCD, S_WAIT} state_t;
  state_t state;

  logic [1:0] k;
  logic an, bn;
  logic [OW:0] am, ad, bm, bd;
  logic [PW-1:0] p1, p2, p3;
  logic rneg;
  logic [GW-1:0] rmag, rden;
  logic gcd_go, gcd_done;
  logic [GW-1:0] gx, gy;

  logic signed [OW-1:0] san, sad, sbn, sbd;
  assign san = a_num[OW-1:0];
  assign sad = a_den[OW-1:0];
  assign sbn = b_num[OW-1:0];
  assign sbd = b_den[OW-1:0];

  function automatic logic [OW:0] mag(input logic signed [OW-1:0] x);
    logic signed [OW:0] e;
    e = {x[OW-1], x};
    return e[OW] ? -e : e;
  endfunction

  rfa_gcd #(.W(GW)) u_gcd (.clk(clk), .rst(rst), .go(gcd_go), .x_in(rmag), .y_in(rden),
    .done(gcd_done), .x_out(gx), .y_out(gy));

  logic signed [PW:0] lhs, rhs;
  assign lhs = an ? -$signed({1'b0, p1}) : $signed({1'b0, p1});
  assign rhs = bn ? -$signed({1'b0, p2}) : $signed({1'b0, p2});
  logic [GW-1:0] s1, s2;
  assign s1 = (ad == bd) ? GW'(am) : GW'(p1);
  assign s2 = (ad == bd) ? GW'(bm) : GW'(p2);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    gcd_go <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          busy <= 1'b1;
          k <= kind;
          if (san == '0) begin an <= 1'b0; am <= '0; ad <= (OW+1)'(1); end
          else begin an <= san[OW-1] ^ sad[OW-1]; am <= mag(san); ad <= mag(sad); end
          if (sbn == '0) begin bn <= 1'b0; bm <= '0; bd <= (OW+1)'(1); end
          else begin bn <= sbn[OW-1] ^ sbd[OW-1]; bm <= mag(sbn); bd <= mag(sbd); end
          state <= S_MUL1;
        end
        S_MUL1: begin
          if (ad == '0 || bd == '0) begin
            done <= 1'b1; status <= 1'b1; flag <= 1'b0;
            res_num <= '0; res_den <= '0; busy <= 1'b0; state <= S_IDLE;
          end else begin
            p1 <= PW'(k == KIND_MUL ? am * bm : am * bd);
            p2 <= PW'(bm * ad);
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          p3 <= PW'(ad * bd);
          state <= S_COMB;
        end
        S_COMB: begin
          status <= 1'b0;
          unique case (kind_t'(k))
            KIND_EQ, KIND_LT: begin
              flag <= (k == KIND_EQ) ? (an == bn && am == bm && ad == bd) : (lhs < rhs);
              res_num <= '0; res_den <= '0; done <= 1'b1; busy <= 1'b0;
              state <= S_IDLE;
            end
            KIND_MUL: begin
              rmag <= GW'(p1); rneg <= (p1 != '0) && (an ^ bn);
              rden <= GW'(p3); state <= S_GCD;
            end
            default: begin
              rden <= (ad == bd) ? GW'(ad) : GW'(p3);
              if (an == bn) begin rneg <= an; rmag <= s1 + s2; end
              else if (s1 >= s2) begin rneg <= an && (s1 != s2); rmag <= s1 - s2; end
              else begin rneg <= bn; rmag <= s2 - s1; end
              state <= S_GCD;
            end
          endcase
        end
        S_GCD: begin
          flag <= 1'b0;
          if (rmag == '0) begin
            res_num <= '0; res_den <= rden[DenWidth-1:0];
            done <= 1'b1; busy <= 1'b0; state <= S_IDLE;
          end else begin
            gcd_go <= 1'b1; state <= S_WAIT;
          end
        end
        S_WAIT: if (gcd_done) begin
          res_num <= rneg ? -gx[NumWidth-1:0] : gx[NumWidth-1:0];
          res_den <= gy[DenWidth-1:0];
          done <= 1'b1; busy <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted beat not busy");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (res_num == '0 && !flag)) else $error("error result nonzero");
`endif
endmodule
`default_nettype wire

### src/rfa_gcd.sv
// Iterative binary GCD with exact division of both inputs by the GCD.
// Depends on rfa_pkg.
`default_nettype none
module rfa_gcd import rfa_pkg::*; #(
  parameter int W = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         go,
  input  wire logic [W-1:0] x_in,
  input  wire logic [W-1:0] y_in,
  output logic              done,
  output logic [W-1:0]      x_out,
  output logic [W-1:0]      y_out
);
  localparam int CW = $clog2(W + 1);

  typedef enum logic [2:0] {S_IDLE, S_TWO, S_SUB, S_DIVX, S_DIVY} gstate_t;
  gstate_t state;

  logic [W-1:0] u, v, xs, ys, g, q, rem;
  logic [CW-1:0] sh, cnt;
  logic [W-1:0] rem_sh;
  logic [W:0]   trial;

  assign rem_sh = {rem[W-2:0], 1'b0};

  // one restoring-divide step per cycle shares the same subtractor width
  always_comb begin
    trial = {1'b0, rem_sh} | {{W{1'b0}}, q[W-1]};
    trial = trial - {1'b0, g};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (go) begin
          u <= x_in; v <= y_in; xs <= x_in; ys <= y_in; sh <= '0;
          state <= S_TWO;
        end
        S_TWO: begin
          if (!u[0] && !v[0]) begin
            u <= u >> 1; v <= v >> 1; sh <= sh + 1'b1;
          end else state <= S_SUB;
        end
        S_SUB: begin
          if (!u[0]) u <= u >> 1;
          else if (!v[0]) v <= v >> 1;
          else if (u == v) begin
            g <= u << sh;
            q <= xs; rem <= '0; cnt <= '0;
            state <= S_DIVX;
          end else if (u > v) u <= (u - v) >> 1;
          else v <= (v - u) >> 1;
        end
        S_DIVX, S_DIVY: begin
          if (!trial[W]) begin
            rem <= trial[W-1:0]; q <= {q[W-2:0], 1'b1};
          end else begin
            rem <= rem_sh | {{(W-1){1'b0}}, q[W-1]}; q <= {q[W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(W - 1)) begin
            cnt <= '0; rem <= '0;
            if (state == S_DIVX) begin
              x_out <= {q[W-2:0], ~trial[W]};
              q <= ys; state <= S_DIVY;
            end else begin
              y_out <= {q[W-2:0], ~trial[W]};
              done <= 1'b1; state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_from_divy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_DIVY) else $error("gcd done out of sequence");
  a_go_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUB) |=> state != S_TWO) else $error("gcd state regressed");
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> cnt == '0) else $error("gcd counter not clear");
`endif
endmodule
`default_nettype wire

### tb/rational_fraction_alu_checker.sv
// Checker for the rational fraction ALU: predicts each result from the accepted
// command beat and compares it with the strobed result. Depends on rfa_pkg.
module rational_fraction_alu_checker import rfa_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic                      busy,
  input  wire logic [1:0]                kind,
  input  wire logic signed [InWidth-1:0] a_num,
  input  wire logic signed [InWidth-1:0] a_den,
  input  wire logic signed [InWidth-1:0] b_num,
  input  wire logic signed [InWidth-1:0] b_den,
  input  wire logic                      done,
  input  wire logic signed [NumWidth-1:0] res_num,
  input  wire logic [DenWidth-1:0]       res_den,
  input  wire logic                      flag,
  input  wire logic                      status,
  output int                             fail_count,
  output int                             pending,
  output int                             result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NumWidth-1:0] num;
    logic [DenWidth-1:0] den;
    logic                flag;
    logic                status;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic alu_result_t compute_result(kind_t op, logic signed [15:0] an,
      logic signed [15:0] ad, logic signed [15:0] bn, logic signed [15:0] bd);
    alu_result_t r;
    longint na, da, nb, db, rn, rd, g;
    r = '0;
    // 0/x and 0/0 both become 0/1; negative denominators flip both signs
    if (an == 0) begin na = 0; da = 1; end
    else if (ad < 0) begin na = -longint'(an); da = -longint'(ad); end
    else begin na = an; da = ad; end
    if (bn == 0) begin nb = 0; db = 1; end
    else if (bd < 0) begin nb = -longint'(bn); db = -longint'(bd); end
    else begin nb = bn; db = bd; end
    if (da == 0 || db == 0) begin
      r.status = 1'b1;
      return r;
    end
    case (op)
      KIND_ADD, KIND_MUL: begin
        if (op == KIND_MUL) begin rn = na * nb; rd = da * db; end
        else if (da == db) begin rn = na + nb; rd = da; end
        else begin rn = na * db + nb * da; rd = da * db; end
        if (rn != 0) begin
          g = gcd_of(rn < 0 ? -rn : rn, rd);
          rn = rn / g;
          rd = rd / g;
        end
        r.num = rn[NumWidth-1:0];
        r.den = rd[DenWidth-1:0];
      end
      KIND_EQ: r.flag = (na == nb) && (da == db);
      default: r.flag = (na * db) < (nb * da);
    endcase
    return r;
  endfunction

  alu_result_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
      expected_results.delete();
    end else begin
      if (done) begin
        got = '{res_num, res_den, flag, status};
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: exp num=%0d den=%0d flag=%0b st=%0b got num=%0d den=%0d flag=%0b st=%0b",
                $signed(want.num), want.den, want.flag, want.status,
                $signed(got.num), got.den, got.flag, got.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        expected_results.push_back(compute_result(kind_t'(kind), a_num, a_den, b_num, b_den));
    end
  end

  assign pending = expected_results.size();
endmodule

### tb/rational_fraction_alu_core_tb.sv
// Testbench top for the rational fraction ALU: clock, reset, command stimulus
// and verdict. Depends on rfa_pkg, rational_fraction_alu_core and the checker.
module rational_fraction_alu_core_tb;
  import rfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0, rst = 1'b1, start = 1'b0;
  logic [1:0] kind = '0;
  logic signed [InWidth-1:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic busy, done, flag, status;
  logic signed [NumWidth-1:0] res_num;
  logic [DenWidth-1:0] res_den;
  int fail_count, pending, result_count;
  int n_directed, n_random;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rational_fraction_alu_core u_dut (.*);
  rational_fraction_alu_checker u_chk (.*);

  // Issue one command beat and hold it until accepted.
  task automatic issue(kind_t op, logic signed [15:0] an, logic signed [15:0] ad,
      logic signed [15:0] bn, logic signed [15:0] bd);
    start <= 1'b1;
    kind <= op;
    a_num <= an; a_den <= ad; b_num <= bn; b_den <= bd;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [15:0] pick_field(bit allow_zero);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return allow_zero ? 16'h0000 : 16'h0001;
      3: return 16'hffff;
      4, 5: return 16'($signed($urandom_range(0, 24)) - 12);
      6: return 16'($signed($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic signed [15:0] ext[6];
    logic [15:0] an, ad, bn, bd;
    int gap;
    ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, -16'sd1, 16'sd2};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // extremes, zero denominators, 0/0, shared denominators, equal by value but not by fields
    foreach (ext[i]) begin
      issue(kind_t'(i % 4), ext[i], ext[(i + 1) % 6], ext[(i + 3) % 6], ext[(i + 5) % 6]);
      n_directed++;
    end
    for (int k = 0; k < 4; k++) begin
      issue(kind_t'(k), 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000);
      issue(kind_t'(k), 16'sd3, 16'sd0, 16'sd1, 16'sd2);
      issue(kind_t'(k), 16'sd0, 16'sd0, -16'sd5, -16'sd7);
      issue(kind_t'(k), 16'sd1, 16'sd2, -16'sd1, 16'sd2);
      issue(kind_t'(k), 16'sd1, 16'sd2, 16'sd2, 16'sd4);
      n_directed += 5;
    end
    for (int i = 0; i < 1850; i++) begin
      if (i < 1600 && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        gap = $urandom_range(1, 16);
        repeat (gap) @(posedge clk);
      end
      an = pick_field(1'b1);
      ad = ($urandom_range(0, 19) == 0) ? 16'h0000 : pick_field(1'b0);
      bn = pick_field(1'b1);
      bd = ($urandom_range(0, 19) == 0) ? 16'h0000 : pick_field(1'b0);
      if ($urandom_range(0, 4) == 0) bd = ad;
      if ($urandom_range(0, 9) == 0) begin bn = an; bd = ad; end
      issue(kind_t'($urandom_range(0, 3)), an, ad, bn, bd);
      n_random++;
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d directed and %0d random commands, %0d results checked",
      n_directed, n_random, result_count);
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
